>>> rtl/finite_time_consensus_step_defines.svh
// Assertion macros of the consensus step RTL.
`ifndef FINITE_TIME_CONSENSUS_STEP_DEFINES_SVH
`define FINITE_TIME_CONSENSUS_STEP_DEFINES_SVH

// Assertion with reset disable.
`define FCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Assertion that also holds during reset.
`define FCS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/fcs_pkg.sv
// Shared types and constants of the consensus step block.
package fcs_pkg;

  localparam int MAX_NEIGHBORS_DEF = 8;
  localparam int FRAC_BITS_DEF     = 10;
  localparam int VAL_W             = 31;
  localparam int STEP_W            = 20;
  localparam int NU_W              = 32;
  localparam int ADDR_W            = 5;
  localparam logic [VAL_W-1:0] VALUE_MAX = {VAL_W{1'b1}};

  typedef enum logic [1:0] {
    REQ_NEIGHBOR = 2'd0,
    REQ_TICK     = 2'd1,
    REQ_LOAD     = 2'd2,
    REQ_NONE     = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    REG_STEP      = 3'd0,
    REG_RATE      = 3'd1,
    REG_THR_ON    = 3'd2,
    REG_THR_OFF   = 3'd3,
    REG_INIT_POS  = 3'd4,
    REG_INIT_VIRT = 3'd5,
    REG_INIT_GAIN = 3'd6,
    REG_UNUSED    = 3'd7
  } reg_idx_t;

  // Square root unit status.
  typedef struct packed {
    logic busy;
    logic done;
  } sq_stat_t;

endpackage

>>> rtl/finite_time_consensus_step.sv
// Neighbor update and load words are taken back to back. A tick passes
// the neighbor scan, a square root for each enabled slot that differs from
// z, and the rate, multiply and add steps for x, z and gain before out_valid
// rises. Throughput: one word at a time; the bit-serial square root unit
// dominates the tick time, and a new word is taken once the tick result
// moves to the output register, held off while the last result waits.
// Reset (rst, synchronous): clears state, neighbor slots, flag and registers
// (step_size to 1); no clearing pass is needed.
module finite_time_consensus_step import fcs_pkg::*; #(
  parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // input words
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          req_type,
  input  logic [2:0]          neighbor_index,
  input  logic [VAL_W-1:0]    neighbor_value,
  input  logic                neighbor_on,
  input  logic signed [NU_W-1:0] disturbance_value,
  // result words
  output logic                out_valid,
  input  logic                out_ready,
  output logic [VAL_W-1:0]    position_out,
  output logic [VAL_W-1:0]    virtual_out,
  output logic [VAL_W-1:0]    gain_out,
  output logic                adapting
);

`include "finite_time_consensus_step_defines.svh"

  localparam int RAD_W    = VAL_W + FRAC_BITS;
  localparam int ROOT_W   = (RAD_W + 1) / 2;
  localparam int NB_IDX_W = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int NB_CNT_W = $clog2(MAX_NEIGHBORS + 1);
  // coupling sum: up to MAX_NEIGHBORS roots of either sign
  localparam int GI_W     = ROOT_W + $clog2(MAX_NEIGHBORS + 1) + 1;
  // Euler rate: gi - gain*sign + nu
  localparam int RATE_W   = ((GI_W > NU_W + 1) ? GI_W : NU_W + 1) + 2;
  localparam int PROD_W   = RATE_W + STEP_W + 1;
  localparam int ACC_W    = ((VAL_W + 1 + FRAC_BITS > PROD_W) ?
                             VAL_W + 1 + FRAC_BITS : PROD_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_NB, S_SQ, S_RATE, S_MUL, S_ADD, S_DONE
  } state_t;

  state_t state;

  // configuration registers
  logic [STEP_W-1:0] step_size;
  logic [VAL_W-1:0]  gain_rate, threshold_on, threshold_off;
  logic [VAL_W-1:0]  initial_position, initial_virtual, initial_gain;

  // node state
  logic [VAL_W-1:0]  position, virtual_position, adaptive_gain;
  logic              adapt_flag;
  logic [VAL_W-1:0]  nb_value [MAX_NEIGHBORS];
  logic [MAX_NEIGHBORS-1:0] nb_valid;

  // tick working registers
  logic signed [NU_W-1:0]   nu;
  logic                     sig_pos, sig_neg;
  logic [NB_CNT_W-1:0]      nb_cnt;
  logic signed [GI_W-1:0]   gi;
  logic                     d_pos;
  logic [1:0]               k;
  logic signed [RATE_W-1:0] rate;
  logic signed [PROD_W-1:0] prod;

  // ---------------- configuration port ----------------
  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  always_comb begin
    unique case (cfg_idx)
      REG_STEP:      prdata = 32'(step_size);
      REG_RATE:      prdata = 32'(gain_rate);
      REG_THR_ON:    prdata = 32'(threshold_on);
      REG_THR_OFF:   prdata = 32'(threshold_off);
      REG_INIT_POS:  prdata = 32'(initial_position);
      REG_INIT_VIRT: prdata = 32'(initial_virtual);
      REG_INIT_GAIN: prdata = 32'(initial_gain);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size        <= STEP_W'(1);
      gain_rate        <= '0;
      threshold_on     <= '0;
      threshold_off    <= '0;
      initial_position <= '0;
      initial_virtual  <= '0;
      initial_gain     <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_STEP:      step_size        <= pwdata[STEP_W-1:0];
        REG_RATE:      gain_rate        <= pwdata[VAL_W-1:0];
        REG_THR_ON:    threshold_on     <= pwdata[VAL_W-1:0];
        REG_THR_OFF:   threshold_off    <= pwdata[VAL_W-1:0];
        REG_INIT_POS:  initial_position <= pwdata[VAL_W-1:0];
        REG_INIT_VIRT: initial_virtual  <= pwdata[VAL_W-1:0];
        REG_INIT_GAIN: initial_gain     <= pwdata[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- tick datapath ----------------
  logic                   in_acc;
  logic signed [VAL_W+1:0] sigma;
  logic [VAL_W:0]         mag;
  logic [VAL_W-1:0]       nb_sel;
  logic signed [VAL_W+1:0] diff;
  logic [VAL_W-1:0]       adiff;
  logic                   sq_start;
  logic [ROOT_W-1:0]      sq_root;
  sq_stat_t               sq_stat;
  logic                   nb_end;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign nb_end   = (nb_cnt == NB_CNT_W'(MAX_NEIGHBORS));

  always_comb begin
    sigma  = $signed({2'b00, position}) - $signed({2'b00, virtual_position});
    mag    = sigma[VAL_W+1] ? (VAL_W+1)'(-sigma) : (VAL_W+1)'(sigma);
    nb_sel = nb_value[nb_cnt[NB_IDX_W-1:0]];
    diff   = $signed({2'b00, virtual_position}) - $signed({2'b00, nb_sel});
    adiff  = diff[VAL_W+1] ? VAL_W'(-diff) : VAL_W'(diff);
    // skip a slot that is off, equal, or past the end of the table
    sq_start = (state == S_NB) && !nb_end && nb_valid[nb_cnt[NB_IDX_W-1:0]]
               && (diff != '0);
  end

  fcs_sqrt #(.RADIX_W(RAD_W)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (RAD_W'(adiff) << FRAC_BITS),
    .root     (sq_root),
    .stat     (sq_stat)
  );

  // Euler rate for the three updates: x, then z, then gain
  logic signed [RATE_W-1:0] rate_next;
  logic signed [RATE_W-1:0] gain_term;

  always_comb begin
    gain_term = sig_pos ? RATE_W'($signed({1'b0, adaptive_gain})) :
                sig_neg ? -RATE_W'($signed({1'b0, adaptive_gain})) : '0;
    case (k)
      2'd0:    rate_next = RATE_W'(gi) - gain_term + RATE_W'(nu);
      2'd1:    rate_next = RATE_W'(gi);
      default: rate_next = adapt_flag ? RATE_W'($signed({1'b0, gain_rate})) : '0;
    endcase
  end

  // accumulate, floor by 2^F, clamp to [0, VALUE_MAX]
  logic [VAL_W-1:0]        v_sel;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] q;
  logic [VAL_W-1:0]        v_new;

  always_comb begin
    case (k)
      2'd0:    v_sel = position;
      2'd1:    v_sel = virtual_position;
      default: v_sel = adaptive_gain;
    endcase
    acc = $signed(ACC_W'(v_sel) << FRAC_BITS) + ACC_W'(prod);
    q   = acc >>> FRAC_BITS;
    // negative or zero sum clamps to zero
    if (acc[ACC_W-1] || (acc == '0))
      v_new = '0;
    else if (q > $signed(ACC_W'(VALUE_MAX)))
      v_new = VALUE_MAX;
    else
      v_new = q[VAL_W-1:0];
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      position         <= '0;
      virtual_position <= '0;
      adaptive_gain    <= '0;
      adapt_flag       <= 1'b0;
      nb_valid         <= '0;
      nb_cnt           <= '0;
      k                <= '0;
      for (int j = 0; j < MAX_NEIGHBORS; j++) nb_value[j] <= '0;
    end else begin
      if (out_valid && out_ready && (state != S_DONE)) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            case (req_type)
              REQ_NEIGHBOR: begin
                for (int j = 0; j < MAX_NEIGHBORS; j++) begin
                  if (32'(neighbor_index) == j) begin
                    nb_value[j] <= neighbor_value;
                    nb_valid[j] <= neighbor_on;
                  end
                end
              end
              REQ_LOAD: begin
                position         <= initial_position;
                virtual_position <= initial_virtual;
                adaptive_gain    <= initial_gain;
              end
              REQ_TICK: begin
                nu      <= disturbance_value;
                sig_pos <= !sigma[VAL_W+1] && (sigma != '0);
                sig_neg <= sigma[VAL_W+1];
                gi      <= '0;
                nb_cnt  <= '0;
                k       <= '0;
                // hysteresis on the old |x-z|
                if (!adapt_flag) begin
                  if (mag > {1'b0, threshold_on}) adapt_flag <= 1'b1;
                end else begin
                  if (mag <= {1'b0, threshold_off}) adapt_flag <= 1'b0;
                end
                state <= S_NB;
              end
              default: ;
            endcase
          end
        end
        S_NB: begin
          if (nb_end) begin
            state <= S_RATE;
          end else if (sq_start) begin
            d_pos <= !diff[VAL_W+1];
            state <= S_SQ;
          end else begin
            nb_cnt <= nb_cnt + 1'b1;
          end
        end
        S_SQ: begin
          if (sq_stat.done) begin
            gi     <= d_pos ? gi - GI_W'($signed({1'b0, sq_root}))
                            : gi + GI_W'($signed({1'b0, sq_root}));
            nb_cnt <= nb_cnt + 1'b1;
            state  <= S_NB;
          end
        end
        S_RATE: begin
          rate  <= rate_next;
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= PROD_W'($signed({1'b0, step_size})) * PROD_W'(rate);
          state <= S_ADD;
        end
        S_ADD: begin
          case (k)
            2'd0:    position         <= v_new;
            2'd1:    virtual_position <= v_new;
            default: adaptive_gain    <= v_new;
          endcase
          if (k == 2'd2) begin
            state <= S_DONE;
          end else begin
            k     <= k + 1'b1;
            state <= S_RATE;
          end
        end
        S_DONE: begin
          // output register frees the datapath once the last word is taken
          if (!out_valid || out_ready) begin
            position_out <= position;
            virtual_out  <= virtual_position;
            gain_out     <= adaptive_gain;
            adapting     <= adapt_flag;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------- checks ----------------
  `FCS_ASSERT(a_sq_in_sq_state, sq_stat.busy |-> (state == S_SQ), "sqrt busy outside wait state")
  `FCS_ASSERT(a_tick_blocks, (in_acc && req_type == REQ_TICK) |=> !in_ready, "tick did not hold off input")
  `FCS_ASSERT(a_sq_start_idle, sq_start |-> !sq_stat.busy, "sqrt restarted while busy")
  `FCS_ASSERT(a_cnt_range, nb_cnt <= NB_CNT_W'(MAX_NEIGHBORS), "neighbor count out of range")

endmodule

>>> rtl/fcs_sqrt.sv
// Bit-serial integer square root, one root bit per cycle.
module fcs_sqrt import fcs_pkg::*; #(
  parameter int RADIX_W = 41
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [RADIX_W-1:0]         radicand,
  output logic [(RADIX_W+1)/2-1:0]   root,
  output sq_stat_t                   stat
);

  localparam int ROOT_W = (RADIX_W + 1) / 2;
  localparam int CNT_W  = $clog2(ROOT_W + 1);

  logic [2*ROOT_W-1:0] rad;
  logic [ROOT_W:0]     remd;
  logic [ROOT_W-1:0]   rootq;
  logic [CNT_W-1:0]    cnt;
  logic                busy;
  logic                done;

  logic [ROOT_W+2:0]   rem_sh;
  logic [ROOT_W+2:0]   trial;
  logic                ge;
  logic [ROOT_W+2:0]   rem_new;

  always_comb begin
    rem_sh  = {remd, rad[2*ROOT_W-1 -: 2]};
    trial   = {1'b0, rootq, 2'b01};
    ge      = (rem_sh >= trial);
    rem_new = ge ? (rem_sh - trial) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rad   <= (2*ROOT_W)'(radicand);
        remd  <= '0;
        rootq <= '0;
        cnt   <= CNT_W'(ROOT_W);
        busy  <= 1'b1;
      end else if (busy) begin
        rad   <= rad << 2;
        remd  <= rem_new[ROOT_W:0];
        rootq <= {rootq[ROOT_W-2:0], ge};
        cnt   <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root      = rootq;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

>>> tb/tb_finite_time_consensus_step.sv
// Self-checking testbench of the finite-time consensus step block.
module tb_finite_time_consensus_step;
  import fcs_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int NSLOT = MAX_NEIGHBORS_DEF;
  localparam longint SAT_MAX = 64'd2147483647;

  // one input word, with an optional hand-written expectation
  typedef struct {
    req_t              req;
    logic [2:0]        idx;
    logic [VAL_W-1:0]  val;
    logic              on;
    logic signed [31:0] nu_val;
    logic              has_exp;
    logic [VAL_W-1:0]  ex_pos;
    logic [VAL_W-1:0]  ex_virt;
    logic [VAL_W-1:0]  ex_gain;
    logic              ex_flag;
  } stim_t;

  typedef struct {
    logic [VAL_W-1:0] pos;
    logic [VAL_W-1:0] virt;
    logic [VAL_W-1:0] gain;
    logic             flag;
  } step_res_t;

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic in_valid, in_ready;
  logic [1:0] req_type;
  logic [2:0] neighbor_index;
  logic [VAL_W-1:0] neighbor_value;
  logic neighbor_on;
  logic signed [NU_W-1:0] disturbance_value;
  logic out_valid, out_ready;
  logic [VAL_W-1:0] position_out, virtual_out, gain_out;
  logic adapting;

  finite_time_consensus_step dut (.*);

  // Mirror of the register file and the node state.
  logic [STEP_W-1:0] cfg_step;
  logic [VAL_W-1:0]  cfg_rate, cfg_thr_on, cfg_thr_off;
  logic [VAL_W-1:0]  cfg_init_pos, cfg_init_virt, cfg_init_gain;
  logic [VAL_W-1:0]  node_pos, node_virt, node_gain;
  logic              node_flag;
  logic [VAL_W-1:0]  slot_val [NSLOT];
  logic              slot_on  [NSLOT];

  step_res_t pending_steps[$];
  int errors = 0;
  int words_sent = 0;
  int steps_checked = 0;
  int stall_mode = 0;
  int stall_cnt = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20000000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // floor((v*2^F + dt*rate) / 2^F), clamped to [0, 2^31-1]
  function automatic logic [VAL_W-1:0] euler_step(logic [VAL_W-1:0] v, longint rate);
    longint acc;
    longint q;
    acc = (longint'(v) <<< FRAC) + longint'({1'b0, cfg_step}) * rate;
    if (acc <= 0) return '0;
    q = acc >>> FRAC;
    if (q > SAT_MAX) q = SAT_MAX;
    return q[VAL_W-1:0];
  endfunction

  // Advance the node model by one accepted word; tick words yield a result.
  task automatic advance_node(input stim_t s, output bit got, output step_res_t r);
    longint x, z, sigma, mag, grad, gi, ui, d, dv;
    longint unsigned rt;
    got = 0;
    r = '{default: '0};
    case (s.req)
      REQ_NEIGHBOR: begin
        if (s.idx < NSLOT) begin
          slot_val[s.idx] = s.val;
          slot_on[s.idx]  = s.on;
        end
      end
      REQ_LOAD: begin
        node_pos  = cfg_init_pos;
        node_virt = cfg_init_virt;
        node_gain = cfg_init_gain;
      end
      REQ_TICK: begin
        x = longint'(node_pos);
        z = longint'(node_virt);
        sigma = x - z;
        mag = sigma < 0 ? -sigma : sigma;
        grad = sigma > 0 ? 1 : (sigma < 0 ? -1 : 0);
        gi = 0;
        for (int j = 0; j < NSLOT; j++) begin
          if (slot_on[j]) begin
            d = z - longint'(slot_val[j]);
            rt = root_floor(longint'(d < 0 ? -d : d) << FRAC);
            if (d > 0) gi -= longint'(rt);
            else if (d < 0) gi += longint'(rt);
          end
        end
        ui = gi - longint'(node_gain) * grad;
        // hysteresis on |x-z|
        if (!node_flag) begin
          if (mag > longint'(cfg_thr_on)) node_flag = 1;
        end else begin
          if (mag <= longint'(cfg_thr_off)) node_flag = 0;
        end
        dv = node_flag ? longint'(cfg_rate) : 0;
        node_pos  = euler_step(node_pos, ui + longint'(s.nu_val));
        node_virt = euler_step(node_virt, gi);
        node_gain = euler_step(node_gain, dv);
        got = 1;
        r = '{node_pos, node_virt, node_gain, node_flag};
      end
      default: ;  // unused request code: ignored
    endcase
  endtask

  task automatic cfg_write(input reg_idx_t ridx, input logic [31:0] data);
    @(negedge clk);
    psel = 1; pwrite = 1; penable = 0;
    paddr = {ridx, 2'b00};
    pwdata = data;
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    case (ridx)
      REG_STEP:      cfg_step      = data[STEP_W-1:0];
      REG_RATE:      cfg_rate      = data[VAL_W-1:0];
      REG_THR_ON:    cfg_thr_on    = data[VAL_W-1:0];
      REG_THR_OFF:   cfg_thr_off   = data[VAL_W-1:0];
      REG_INIT_POS:  cfg_init_pos  = data[VAL_W-1:0];
      REG_INIT_VIRT: cfg_init_virt = data[VAL_W-1:0];
      REG_INIT_GAIN: cfg_init_gain = data[VAL_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  // Called at a falling edge; holds valid until the word is taken and
  // returns at the next falling edge with valid still high.
  task automatic send_word(input stim_t s);
    bit got;
    step_res_t r;
    in_valid = 1;
    req_type = s.req;
    neighbor_index = s.idx;
    neighbor_value = s.val;
    neighbor_on = s.on;
    disturbance_value = s.nu_val;
    do @(posedge clk); while (!in_ready);
    advance_node(s, got, r);
    if (got) begin
      if (s.has_exp) r = '{s.ex_pos, s.ex_virt, s.ex_gain, s.ex_flag};
      pending_steps.push_back(r);
    end
    if (s.req != REQ_NONE) words_sent++;
    @(negedge clk);
  endtask

  function automatic stim_t mk(req_t q, int i, logic [30:0] v, bit o, logic [31:0] nu);
    stim_t s;
    s = '{req: REQ_NEIGHBOR, default: '0};
    s.req = q; s.idx = i[2:0]; s.val = v; s.on = o; s.nu_val = nu;
    return s;
  endfunction

  function automatic stim_t mk_exp(stim_t s, logic [30:0] p, logic [30:0] z,
                                   logic [30:0] g, bit f);
    s.has_exp = 1;
    s.ex_pos = p; s.ex_virt = z; s.ex_gain = g; s.ex_flag = f;
    return s;
  endfunction

  // Random word; most neighbor values sit near z so the roots stay varied.
  function automatic stim_t rand_word();
    stim_t s;
    int pick;
    longint nv;
    s = mk(REQ_TICK, 0, '0, 0, '0);
    pick = $urandom_range(0, 99);
    if (pick < 40) s.req = REQ_NEIGHBOR;
    else if (pick < 85) s.req = REQ_TICK;
    else if (pick < 93) s.req = REQ_LOAD;
    else s.req = REQ_NONE;
    s.idx = 3'($urandom_range(0, 7));
    s.on = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 3) == 0) begin
      s.val = VAL_W'($urandom);
    end else begin
      nv = longint'(node_virt) + $signed($urandom_range(0, 200000)) - 100000;
      if (nv < 0) nv = 0;
      if (nv > SAT_MAX) nv = SAT_MAX;
      s.val = nv[VAL_W-1:0];
    end
    case ($urandom_range(0, 3))
      0: s.nu_val = $urandom;
      1: s.nu_val = $signed($urandom_range(0, 2000)) - 1000;
      2: s.nu_val = $signed($urandom_range(0, 2000000)) - 1000000;
      default: s.nu_val = 0;
    endcase
    return s;
  endfunction

  // Result side: the receiver stalls according to stall_mode.
  always @(negedge clk) begin
    if (rst) begin
      out_ready = 0;
    end else begin
      case (stall_mode)
        0: out_ready = 1;
        1: out_ready = $urandom_range(0, 1);
        default: begin
          // long stall stretches with open windows in between
          if (stall_cnt == 0) begin
            out_ready = ~out_ready;
            stall_cnt = $urandom_range(1, 25);
          end else begin
            stall_cnt--;
          end
        end
      endcase
    end
  end

  always @(posedge clk) begin
    step_res_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_steps.size() == 0) begin
        $display("%0t: unexpected result word pos=%0d virt=%0d gain=%0d flag=%0d",
                 $time, position_out, virtual_out, gain_out, adapting);
        errors++;
      end else begin
        e = pending_steps.pop_front();
        steps_checked++;
        if (position_out !== e.pos) begin
          $display("%0t: position_out expected %0d actual %0d", $time, e.pos, position_out);
          errors++;
        end
        if (virtual_out !== e.virt) begin
          $display("%0t: virtual_out expected %0d actual %0d", $time, e.virt, virtual_out);
          errors++;
        end
        if (gain_out !== e.gain) begin
          $display("%0t: gain_out expected %0d actual %0d", $time, e.gain, gain_out);
          errors++;
        end
        if (adapting !== e.flag) begin
          $display("%0t: adapting expected %0d actual %0d", $time, e.flag, adapting);
          errors++;
        end
      end
    end
  end

  task automatic drain();
    while (pending_steps.size() != 0) @(posedge clk);
    // a trailing non-tick word may still be in flight
    repeat (300) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_random(input int count);
    int burst;
    int sent;
    burst = 0;
    sent = 0;
    while (sent < count) begin
      if (burst == 0) begin
        in_valid = 0;
        repeat ($urandom_range(0, 12)) @(negedge clk);
        burst = $urandom_range(1, 20);
      end
      send_word(rand_word());
      burst--;
      sent++;
    end
    in_valid = 0;
  endtask

  stim_t dir_rows[$];

  initial begin
    rst = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid = 0; req_type = REQ_NEIGHBOR; neighbor_index = '0;
    neighbor_value = '0; neighbor_on = 0; disturbance_value = '0;
    out_ready = 0;
    cfg_step = 1; cfg_rate = '0; cfg_thr_on = '0; cfg_thr_off = '0;
    cfg_init_pos = '0; cfg_init_virt = '0; cfg_init_gain = '0;
    node_pos = '0; node_virt = '0; node_gain = '0; node_flag = 0;
    for (int j = 0; j < NSLOT; j++) begin
      slot_val[j] = '0;
      slot_on[j] = 0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed part, reset register values (dt = 1 LSB, no adaptation).
    dir_rows.push_back(mk_exp(mk(REQ_TICK, 0, '0, 0, 32'd0), '0, '0, '0, 0));
    dir_rows.push_back(mk(REQ_TICK, 0, '0, 0, 32'h7FFF_FFFF));
    dir_rows.push_back(mk(REQ_TICK, 0, '0, 0, 32'h8000_0000));
    dir_rows.push_back(mk(REQ_NEIGHBOR, 0, 31'h7FFF_FFFF, 1, '0));
    dir_rows.push_back(mk(REQ_NEIGHBOR, 7, '0, 1, '0));
    dir_rows.push_back(mk(REQ_NEIGHBOR, 3, 31'd12345, 0, '0));
    dir_rows.push_back(mk(REQ_TICK, 0, '0, 0, 32'd5000));
    dir_rows.push_back(mk(REQ_NONE, 5, 31'd777, 1, 32'hFFFF_FFFF));
    dir_rows.push_back(mk(REQ_TICK, 0, '0, 0, 32'hFFFF_0000));
    dir_rows.push_back(mk(REQ_LOAD, 0, '0, 0, '0));
    dir_rows.push_back(mk(REQ_NEIGHBOR, 0, '0, 0, '0));
    // z equals the only enabled neighbor: no coupling, state stays at zero
    dir_rows.push_back(mk_exp(mk(REQ_TICK, 0, '0, 0, 32'd0), '0, '0, '0, 0));
    for (int j = 0; j < NSLOT; j++)
      dir_rows.push_back(mk(REQ_NEIGHBOR, j, 31'd1 << (j * 4), 1, '0));
    dir_rows.push_back(mk(REQ_TICK, 0, '0, 0, 32'd1));
    dir_rows.push_back(mk(REQ_TICK, 0, '0, 0, 32'h0000_FFFF));
    foreach (dir_rows[k]) send_word(dir_rows[k]);
    in_valid = 0;
    drain();

    // Phases with fresh settings; each opens with a load.
    for (int ph = 1; ph <= 5; ph++) begin
      stall_mode = ph % 3;
      case (ph)
        1: begin
          cfg_write(REG_STEP, 32'hFFFFF);
          cfg_write(REG_RATE, 32'h7FFF_FFFF);
          cfg_write(REG_THR_ON, 32'h7FFF_FFFF);
          cfg_write(REG_THR_OFF, 32'h7FFF_FFFF);
          cfg_write(REG_INIT_POS, 32'h7FFF_FFFF);
          cfg_write(REG_INIT_VIRT, 32'h0);
          cfg_write(REG_INIT_GAIN, 32'h7FFF_FFFF);
        end
        2: begin
          cfg_write(REG_STEP, 32'h0);
          cfg_write(REG_RATE, 32'h0);
          cfg_write(REG_THR_ON, 32'h0);
          cfg_write(REG_THR_OFF, 32'h0);
          cfg_write(REG_INIT_POS, 32'h0);
          cfg_write(REG_INIT_VIRT, 32'h7FFF_FFFF);
          cfg_write(REG_INIT_GAIN, 32'h0);
        end
        default: begin
          cfg_write(REG_STEP, $urandom_range(1, 2048));
          cfg_write(REG_RATE, $urandom_range(0, 1 << 20));
          cfg_write(REG_THR_ON, $urandom_range(0, 1 << 18));
          cfg_write(REG_THR_OFF, $urandom_range(0, 1 << 16));
          cfg_write(REG_INIT_POS, $urandom);
          cfg_write(REG_INIT_VIRT, $urandom);
          cfg_write(REG_INIT_GAIN, $urandom_range(0, 1 << 22));
        end
      endcase
      // write past the last register: must have no effect
      cfg_write(REG_UNUSED, $urandom);
      send_word(mk(REQ_LOAD, 0, '0, 0, '0));
      in_valid = 0;
      run_random(250);
      drain();
    end

    $display("Covered %0d input words over six register settings,", words_sent);
    $display("%0d tick results compared, %0d mismatches.", steps_checked, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> finite_time_consensus_step.f
+incdir+rtl
rtl/fcs_pkg.sv
rtl/fcs_sqrt.sv
rtl/finite_time_consensus_step.sv
tb/tb_finite_time_consensus_step.sv
